@@ hw/rtl/union_find_link_compress_defines.svh @@
// assertion macros shared by the union-find block
`ifndef UNION_FIND_LINK_COMPRESS_DEFINES_SVH
`define UNION_FIND_LINK_COMPRESS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define UFLC_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uflc check failed");
// next-cycle implication
`define UFLC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uflc check failed");
`else
`define UFLC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define UFLC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/uflc_pkg.sv @@
package uflc_pkg;

  localparam int VERTEX_W = 12;
  localparam int LABEL_W  = 12;
  localparam int ACTIVE_W = 13;

  localparam int MAX_VERTICES_DEFAULT = 4096;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 13'd4096;

  typedef enum logic [1:0] {
    CMD_LINK     = 2'd0,
    CMD_COMPRESS = 2'd1,
    CMD_READ     = 2'd2,
    CMD_INIT     = 2'd3
  } cmd_t;

  // one classified command waiting for the back end
  typedef struct packed {
    cmd_t                cmd;
    logic                in_range;
    logic [VERTEX_W-1:0] first;
    logic [VERTEX_W-1:0] second;
  } entry_t;

endpackage

@@ hw/rtl/union_find_link_compress.sv @@
// channel  | direction | transaction marker     | payload
// command  | in        | start high, busy low   | cmd, first_vertex, second_vertex
// result   | out       | done high, one cycle   | label
// config   | in        | cfg_en high            | cfg_data (active_vertices)
//
// commands enter a queue of QUEUE_DEPTH; busy is high while it is full
// back end steps, from the idle state that pops the command: read does one lookup, link
//   reads both roots and stops when they match, else walks further turns; init writes
//   each covered entry, compress visits each covered entry plus each pointer jump, and
//   an out-of-range vertex or a sweep with nothing covered ends at once; all paced by the
//   single read port of the parent memory, each result registered in the cycle after the last step
// after reset a clearing pass writes identity over MAX_VERTICES entries, one a
//   cycle, with busy high; cfg writes are taken during it
// the receiver cannot stall: each result shows for exactly one cycle
module union_find_link_compress
  import uflc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // command side
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [VERTEX_W-1:0] first_vertex,
  input  logic [VERTEX_W-1:0] second_vertex,
  // result side
  output logic                done,
  output logic [LABEL_W-1:0]  label,
  // configuration
  input  logic                cfg_en,
  input  logic [ACTIVE_W-1:0] cfg_data
);

  // number of entries compress and init cover
  logic [ACTIVE_W-1:0] active_vertices;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  entry_t q_head;
  logic   clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_vertices <= ACTIVE_RESET;
    end else if (cfg_en) begin
      active_vertices <= cfg_data;
    end
  end

  // front: handshake and range classification
  uflc_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .start         (start),
    .cmd           (cmd),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .full          (q_full),
    .clearing      (clearing),
    .busy          (busy),
    .push          (push),
    .push_entry    (push_entry)
  );

  // short queue decoupling command intake from table work
  uflc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // back: sequencer over the parent memory, one transaction at a time
  uflc_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .active_vertices (active_vertices),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .done            (done),
    .label           (label)
  );

endmodule

@@ hw/rtl/uflc_ram.sv @@
module uflc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/uflc_front.sv @@
module uflc_front
  import uflc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  logic                start,
  input  logic [1:0]          cmd,
  input  logic [VERTEX_W-1:0] first_vertex,
  input  logic [VERTEX_W-1:0] second_vertex,
  input  logic                full,
  input  logic                clearing,
  output logic                busy,
  output logic                push,
  output entry_t              push_entry
);

  localparam logic [31:0] MAX_WIDE = 32'(MAX_VERTICES);

  cmd_t cmd_dec;
  logic first_ok;
  logic second_ok;

  assign cmd_dec   = cmd_t'(cmd);
  assign first_ok  = 32'(first_vertex) < MAX_WIDE;
  assign second_ok = 32'(second_vertex) < MAX_WIDE;

  assign busy = full | clearing;
  assign push = start & ~busy;

  always_comb begin
    push_entry.cmd    = cmd_dec;
    push_entry.first  = first_vertex;
    push_entry.second = second_vertex;
    case (cmd_dec)
      CMD_LINK: begin
        push_entry.in_range = first_ok & second_ok;
      end
      CMD_READ: begin
        push_entry.in_range = first_ok;
      end
      default: begin
        push_entry.in_range = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/uflc_queue.sv @@
`include "union_find_link_compress_defines.svh"

module uflc_queue
  import uflc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t         slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == FULL_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `UFLC_ASSERT_IMPL(a_no_push_when_full, clk, rst, push, !full)
  `UFLC_ASSERT_IMPL(a_no_pop_when_empty, clk, rst, pop, !empty)
  `UFLC_ASSERT_NEXT(a_count_tracks_push, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

@@ hw/rtl/uflc_back.sv @@
`include "union_find_link_compress_defines.svh"

module uflc_back
  import uflc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ACTIVE_W-1:0] active_vertices,
  input  logic                q_empty,
  input  entry_t              q_head,
  output logic                q_pop,
  output logic                clearing,
  output logic                done,
  output logic [LABEL_W-1:0]  label
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = AW + 1;
  localparam int LW = (CW > ACTIVE_W) ? CW : ACTIVE_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
  localparam logic [LW-1:0] MAX_WIDE  = LW'(MAX_VERTICES);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_VERTICES);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_LINK_R1  = 9'b000000100,
    S_LINK_CMP = 9'b000001000,
    S_LINK_HP  = 9'b000010000,
    S_CMP_P    = 9'b000100000,
    S_CMP_Q    = 9'b001000000,
    S_INIT     = 9'b010000000,
    S_READ     = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next, cnt_inc;
  logic [CW-1:0] lim, lim_next, lim_now;
  logic [AW-1:0] r1, r1_next;
  logic [AW-1:0] hi, hi_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] sec, sec_next;
  logic [AW-1:0] p, p_next;
  logic [AW-1:0] hi_w, lo_w;
  logic          lim_zero;

  logic               emit;
  logic [LABEL_W-1:0] emit_label;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;

  uflc_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_VERTICES)
  ) u_parent (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // covered entries: active count capped at the table size
  assign lim_now  = (LW'(active_vertices) > MAX_WIDE) ? MAX_CNT : CW'(active_vertices);
  assign lim_zero = (active_vertices == '0);
  assign cnt_inc  = cnt + 1'b1;
  assign hi_w     = (r1 > rd_data) ? r1 : rd_data;
  assign lo_w     = (r1 > rd_data) ? rd_data : r1;
  assign clearing = (state == S_CLEAR);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    lim_next   = lim;
    r1_next    = r1;
    hi_next    = hi;
    lo_next    = lo;
    sec_next   = sec;
    p_next     = p;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_label = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[AW-1:0];
        wr_data = cnt[AW-1:0];
        if (cnt[AW-1:0] == LAST_ADDR) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.cmd)
            CMD_LINK: begin
              if (!q_head.in_range) begin
                emit = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = AW'(q_head.first);
                sec_next   = AW'(q_head.second);
                state_next = S_LINK_R1;
              end
            end
            CMD_COMPRESS: begin
              if (lim_zero) begin
                emit = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                cnt_next   = '0;
                lim_next   = lim_now;
                state_next = S_CMP_P;
              end
            end
            CMD_READ: begin
              if (!q_head.in_range) begin
                emit = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = AW'(q_head.first);
                state_next = S_READ;
              end
            end
            CMD_INIT: begin
              if (lim_zero) begin
                emit = 1'b1;
              end else begin
                cnt_next   = '0;
                lim_next   = lim_now;
                state_next = S_INIT;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_LINK_R1: begin
        r1_next    = rd_data;
        rd_en      = 1'b1;
        rd_addr    = sec;
        state_next = S_LINK_CMP;
      end
      S_LINK_CMP: begin
        if (r1 == rd_data) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          hi_next    = hi_w;
          lo_next    = lo_w;
          rd_en      = 1'b1;
          rd_addr    = hi_w;
          state_next = S_LINK_HP;
        end
      end
      S_LINK_HP: begin
        if (rd_data == lo) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else if (rd_data == hi) begin
          // higher root still its own parent: hook it under the lower
          wr_en      = 1'b1;
          wr_addr    = hi;
          wr_data    = lo;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = rd_data;
          sec_next   = lo;
          state_next = S_LINK_R1;
        end
      end
      S_CMP_P: begin
        p_next     = rd_data;
        rd_en      = 1'b1;
        rd_addr    = rd_data;
        state_next = S_CMP_Q;
      end
      S_CMP_Q: begin
        if (rd_data != p) begin
          // one jump: entry takes its grandparent
          wr_en   = 1'b1;
          wr_addr = cnt[AW-1:0];
          wr_data = rd_data;
          p_next  = rd_data;
          rd_en   = 1'b1;
          rd_addr = rd_data;
        end else if (cnt_inc == lim) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next   = cnt_inc;
          rd_en      = 1'b1;
          rd_addr    = cnt_inc[AW-1:0];
          state_next = S_CMP_P;
        end
      end
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = cnt[AW-1:0];
        wr_data = cnt[AW-1:0];
        if (cnt_inc == lim) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      S_READ: begin
        emit       = 1'b1;
        emit_label = LABEL_W'(rd_data);
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= emit;
    end
    lim   <= lim_next;
    r1    <= r1_next;
    hi    <= hi_next;
    lo    <= lo_next;
    sec   <= sec_next;
    p     <= p_next;
    label <= emit_label;
  end

  `UFLC_ASSERT_NEXT(a_no_result_while_clearing, clk, rst, state == S_CLEAR, !done)
  `UFLC_ASSERT_IMPL(a_entry_not_above_index, clk, rst, wr_en, wr_data <= wr_addr)
  `UFLC_ASSERT_NEXT(a_label_only_from_read, clk, rst, state != S_READ, label == '0)

endmodule
